### rtl/core/ntip_pkg.sv
// ntip_pkg: shared types and constants for the nibble trie counter table
// no dependencies
`default_nettype none
package ntip_pkg;
  localparam int unsigned FANOUT = 16;
  localparam int unsigned NIB_W = 4;
  localparam int unsigned LEVELS = 8;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned OUT_W = 32;
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_WALK,
    ST_LEAF_RD,
    ST_LEAF_WR,
    ST_DONE
  } state_t;

  // status from the walker to the controller
  typedef struct packed {
    logic       done;
    logic [3:0] depth;
  } walk_stat_t;
endpackage
`default_nettype wire

### rtl/core/ntip_if.sv
// ntip_if: valid/ready channel interfaces for input and result transactions
// depends on no other file
`default_nettype none
interface ntip_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] ip_address;
  logic [31:0] add_first;
  logic [31:0] add_second;
  logic [31:0] add_third;
  logic [31:0] add_fourth;
  modport source (output valid, op, ip_address, add_first, add_second, add_third,
                  add_fourth, input ready);
  modport sink (input valid, op, ip_address, add_first, add_second, add_third,
                add_fourth, output ready);
endinterface

interface ntip_out_if;
  logic        valid;
  logic        ready;
  logic        success;
  logic [31:0] count_first;
  logic [31:0] count_second;
  logic [31:0] count_third;
  logic [31:0] count_fourth;
  logic [31:0] insert_total;
  modport source (output valid, success, count_first, count_second, count_third,
                  count_fourth, insert_total, input ready);
  modport sink (input valid, success, count_first, count_second, count_third,
                count_fourth, insert_total, output ready);
endinterface
`default_nettype wire

### rtl/core/ntip_link_mem.sv
// ntip_link_mem: child link memory, one write and one registered read port
// depends on nothing but its parameters
`default_nettype none
module ntip_link_mem #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW = 14,
  parameter int unsigned DW = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/core/ntip_leaf_mem.sv
// ntip_leaf_mem: leaf counter memory, four counters per entry
// depends on nothing but its parameters
`default_nettype none
module ntip_leaf_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW = 10,
  parameter int unsigned DW = 128
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/core/nibble_trie_ip_counter_table_top.sv
// nibble_trie_ip_counter_table_top: 16-way trie exact-match table with leaf counters
// depends on ntip_pkg, ntip_if, ntip_link_mem, ntip_leaf_mem
// walk: each trie level issues a link read, then checks it; each fresh node of an insert
//   is linked in its own step; then leaf read, leaf write on insert, done
// flow: one transaction at a time; no new one is accepted until the last result is taken
// reset: a clearing pass writes every link empty; no input transaction is accepted
//   during it
`default_nettype none
module nibble_trie_ip_counter_table_top #(
  parameter int unsigned POOL_NODES = 1024,
  parameter int unsigned COUNTER_BITS = 32
) (
  input wire logic   clk,
  input wire logic   rst_n,
  ntip_in_if.sink    in_ch,
  ntip_out_if.source out_ch
);
  localparam int unsigned NODE_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned LINK_AW = NODE_W + ntip_pkg::NIB_W;
  localparam int unsigned LINK_DEPTH = POOL_NODES * ntip_pkg::FANOUT;
  localparam int unsigned LEAF_W = 4 * COUNTER_BITS;
  localparam int unsigned TAKEN_W = NODE_W + 1;

  ntip_pkg::state_t state_r, state_nxt;

  // transaction capture
  logic                    op_r;
  logic [31:0]             key_r;
  logic [3:0][31:0]        add_r;

  // walk state
  logic [3:0]              lvl_r, lvl_nxt;
  logic [NODE_W-1:0]       node_r, node_nxt;
  logic                    rd_pend_r, rd_pend_nxt;
  logic                    ext_r, ext_nxt;   // extending path with fresh nodes
  logic [TAKEN_W-1:0]      taken_r, taken_nxt;
  logic [LINK_AW:0]        clr_r;
  logic [31:0]             total_r, total_nxt;
  logic                    new_leaf_r, new_leaf_nxt;
  logic                    ok_r, ok_nxt;

  // output register
  logic                    ovalid_r;
  logic                    osucc_r;
  logic [3:0][31:0]        ocnt_r;
  logic [31:0]             ototal_r;

  // memory ports
  logic                    lk_we;
  logic [LINK_AW-1:0]      lk_waddr, lk_raddr;
  logic [NODE_W-1:0]       lk_wdata, lk_rdata;
  logic                    lf_we;
  logic [LEAF_W-1:0]       lf_wdata, lf_rdata;
  logic [LEAF_W-1:0]       leaf_sum;
  ntip_pkg::walk_stat_t    wstat;

  logic in_fire, out_fire;
  logic [3:0] missing;

  assign in_ch.ready = (state_r == ntip_pkg::ST_IDLE) && !ovalid_r;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  // path address at the current level
  function automatic logic [3:0] nib_of(input logic [31:0] k, input logic [3:0] l);
    nib_of = k[{l[2:0], 2'b00} +: 4];
  endfunction

  assign lk_raddr = {node_r, nib_of(key_r, lvl_r)};

  ntip_link_mem #(.DEPTH(LINK_DEPTH), .AW(LINK_AW), .DW(NODE_W)) u_links (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(lk_raddr), .rdata(lk_rdata)
  );

  ntip_leaf_mem #(.DEPTH(POOL_NODES), .AW(NODE_W), .DW(LEAF_W)) u_leaves (
    .clk(clk), .we(lf_we), .waddr(node_r), .wdata(lf_wdata),
    .raddr(node_r), .rdata(lf_rdata)
  );

  // counter add, new leaf starts from zero
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      leaf_sum[j*COUNTER_BITS +: COUNTER_BITS] =
        (new_leaf_r ? COUNTER_BITS'(0) : lf_rdata[j*COUNTER_BITS +: COUNTER_BITS])
        + COUNTER_BITS'(add_r[j]);
    end
  end
  assign lf_wdata = leaf_sum;

  assign wstat.done = rd_pend_r && ((lk_rdata == '0) || (lvl_r == 4'd7));
  assign wstat.depth = (lk_rdata == '0) ? lvl_r : lvl_r + 4'd1;
  assign missing = 4'(ntip_pkg::LEVELS) - wstat.depth;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ntip_pkg::ST_CLEAR:   if (clr_r[LINK_AW]) state_nxt = ntip_pkg::ST_IDLE;
      ntip_pkg::ST_IDLE:    if (in_fire) state_nxt = ntip_pkg::ST_WALK;
      ntip_pkg::ST_WALK: begin
        if (ext_r) begin
          if (lvl_r == 4'd7) state_nxt = ntip_pkg::ST_LEAF_RD;
        end else if (wstat.done) begin
          if (op_r == ntip_pkg::OP_LOOKUP)
            state_nxt = (wstat.depth == 4'd8) ? ntip_pkg::ST_LEAF_RD : ntip_pkg::ST_DONE;
          else if (32'(taken_r) + 32'(missing) > 32'(POOL_NODES))
            state_nxt = ntip_pkg::ST_DONE;
          else if (wstat.depth == 4'd8)
            state_nxt = ntip_pkg::ST_LEAF_RD;
        end
      end
      ntip_pkg::ST_LEAF_RD:
        state_nxt = (op_r == ntip_pkg::OP_LOOKUP) ? ntip_pkg::ST_DONE : ntip_pkg::ST_LEAF_WR;
      ntip_pkg::ST_LEAF_WR: state_nxt = ntip_pkg::ST_DONE;
      ntip_pkg::ST_DONE:    state_nxt = ntip_pkg::ST_IDLE;
      default:              state_nxt = ntip_pkg::ST_CLEAR;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    lvl_nxt = lvl_r;
    node_nxt = node_r;
    rd_pend_nxt = 1'b0;
    ext_nxt = ext_r;
    taken_nxt = taken_r;
    total_nxt = total_r;
    new_leaf_nxt = new_leaf_r;
    ok_nxt = ok_r;
    lk_we = 1'b0;
    lk_waddr = lk_raddr;
    lk_wdata = taken_r[NODE_W-1:0];
    lf_we = 1'b0;
    unique case (state_r)
      ntip_pkg::ST_CLEAR: begin
        lk_we = 1'b1;
        lk_waddr = clr_r[LINK_AW-1:0];
        lk_wdata = '0;
      end
      ntip_pkg::ST_IDLE: begin
        // the first link read is issued in the walk, once the key is captured
        lvl_nxt = '0;
        node_nxt = '0;
        ext_nxt = 1'b0;
        new_leaf_nxt = 1'b0;
        ok_nxt = 1'b0;
      end
      ntip_pkg::ST_WALK: begin
        if (ext_r) begin
          // link a fresh node at this level
          lk_we = 1'b1;
          node_nxt = taken_r[NODE_W-1:0];
          taken_nxt = taken_r + TAKEN_W'(1);
          if (lvl_r == 4'd7) new_leaf_nxt = 1'b1;
          else lvl_nxt = lvl_r + 4'd1;
        end else if (rd_pend_r) begin
          if (lk_rdata != '0) node_nxt = lk_rdata;
          if (wstat.done) begin
            if (op_r == ntip_pkg::OP_LOOKUP) begin
              ok_nxt = (wstat.depth == 4'd8);
            end else if (32'(taken_r) + 32'(missing) <= 32'(POOL_NODES)) begin
              ok_nxt = 1'b1;
              if (wstat.depth != 4'd8) ext_nxt = 1'b1;
            end
          end else begin
            lvl_nxt = lvl_r + 4'd1;
          end
        end else begin
          rd_pend_nxt = 1'b1;
        end
      end
      ntip_pkg::ST_LEAF_WR: begin
        lf_we = 1'b1;
        if (total_r != 32'hFFFF_FFFF) total_nxt = total_r + 32'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ntip_pkg::ST_CLEAR;
      clr_r <= '0;
      taken_r <= TAKEN_W'(1);
      total_r <= '0;
      ovalid_r <= 1'b0;
      rd_pend_r <= 1'b0;
      ext_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ntip_pkg::ST_CLEAR) clr_r <= clr_r + (LINK_AW+1)'(1);
      taken_r <= taken_nxt;
      total_r <= total_nxt;
      rd_pend_r <= rd_pend_nxt;
      ext_r <= ext_nxt;
      if (state_r == ntip_pkg::ST_DONE) ovalid_r <= 1'b1;
      else if (out_fire) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r <= lvl_nxt;
    node_r <= node_nxt;
    new_leaf_r <= new_leaf_nxt;
    ok_r <= ok_nxt;
    if (in_fire) begin
      op_r <= in_ch.op;
      key_r <= in_ch.ip_address;
      add_r <= {in_ch.add_fourth, in_ch.add_third, in_ch.add_second, in_ch.add_first};
    end
    // result capture: lookup hit takes the leaf read issued in leaf_rd,
    // insert takes the written sum
    if (state_r == ntip_pkg::ST_DONE && op_r == ntip_pkg::OP_LOOKUP && ok_r) begin
      for (int j = 0; j < 4; j++)
        ocnt_r[j] <= 32'(lf_rdata[j*COUNTER_BITS +: COUNTER_BITS]);
    end else if (state_r == ntip_pkg::ST_LEAF_WR) begin
      for (int j = 0; j < 4; j++)
        ocnt_r[j] <= 32'(leaf_sum[j*COUNTER_BITS +: COUNTER_BITS]);
    end else if (state_r == ntip_pkg::ST_WALK) begin
      ocnt_r <= '0;
    end
    if (state_r == ntip_pkg::ST_DONE) begin
      osucc_r <= ok_r;
      ototal_r <= total_r;
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.success = osucc_r;
  assign out_ch.count_first = ocnt_r[0];
  assign out_ch.count_second = ocnt_r[1];
  assign out_ch.count_third = ocnt_r[2];
  assign out_ch.count_fourth = ocnt_r[3];
  assign out_ch.insert_total = ototal_r;

  // pool never overflows
  a_pool: assert property (@(posedge clk) disable iff (!rst_n)
    32'(taken_r) <= 32'(POOL_NODES))
    else $error("node pool overrun");
  // total never decreases
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> total_r >= $past(total_r))
    else $error("insert total decreased");
  // no accept while a result waits
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> !in_ch.ready)
    else $error("accept with pending result");
endmodule
`default_nettype wire
